FILE: hdl/mmle_pkg.sv
package mmle_pkg;

   localparam logic signed [1:0] LEVEL_ZERO = 2'sb00;
   localparam logic signed [1:0] LEVEL_POS  = 2'sb01;
   localparam logic signed [1:0] LEVEL_NEG  = 2'sb11;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_V    = 2'd1,
      KIND_B    = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      CODE_UNIPOLAR  = 4'd0,
      CODE_NRZ_L     = 4'd1,
      CODE_NRZ_I     = 4'd2,
      CODE_MANCH     = 4'd3,
      CODE_DIFF_MAN  = 4'd4,
      CODE_AMI       = 4'd5,
      CODE_PSEUDO    = 4'd6,
      CODE_HDB3      = 4'd7,
      CODE_B8ZS      = 4'd8
   } code_type;

   typedef enum logic [1:0] {
      TAIL_NONE   = 2'd0,
      TAIL_SYMBOL = 2'd1,
      TAIL_HDB3   = 2'd2,
      TAIL_B8ZS   = 2'd3
   } tail_type;

   localparam int unsigned HDB3_LEN = 4;
   localparam int unsigned B8ZS_LEN = 8;

   localparam logic [2:0] CSR_ADDR_LINE_CODE = 3'd0;

   // one queue entry: plain zeros first, then the tail
   typedef struct packed {
      logic [2:0]        zero_count;
      tail_type          tail;
      logic signed [1:0] first_half;
      logic signed [1:0] second_half;
      kind_type          kind;
      logic              pulse_pos;
      logic              balance;
   } cmd_type;

   function automatic logic signed [1:0] pol(input logic positive);
      return positive ? LEVEL_POS : LEVEL_NEG;
   endfunction

endpackage

FILE: hdl/multi_mode_line_encoder_unit.sv
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// request   | push / full            | req_data_bit, req_end_of_stream
// response  | empty / pop            | rsp_first_half_level, rsp_second_half_level,
//           |                        | rsp_symbol_kind, rsp_last_of_run
// csr       | psel penable pwrite    | paddr, pwdata, prdata (line_code at 0x0)
//
// One request per cycle is taken while the command queue has room; its first result
// goes through a queue entry, then the output register. The back end emits one
// result per cycle unless pop stalls it; a request with n results (up to 8) holds
// its queue entry until its last result is loaded. Synchronous active-high reset
// clears the queue, output valid flag and state. full rises only when the
// DEPTH-entry queue fills; pop stalls only the back end and its output register.
module multi_mode_line_encoder_unit #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic              req_data_bit,
   input  logic              req_end_of_stream,
   output logic              empty,
   input  logic              pop,
   output logic signed [1:0] rsp_first_half_level,
   output logic signed [1:0] rsp_second_half_level,
   output logic [1:0]        rsp_symbol_kind,
   output logic              rsp_last_of_run,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   mmle_pkg::cmd_type front_cmd;
   mmle_pkg::cmd_type head_cmd;
   logic              front_push;
   logic              queue_full;
   logic              head_valid;
   logic              head_pop;

   mmle_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_data_bit      (req_data_bit),
      .req_end_of_stream (req_end_of_stream),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .cmd_full          (queue_full),
      .cmd_push          (front_push),
      .cmd               (front_cmd)
   );

   mmle_cmd_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (front_push),
      .in_cmd    (front_cmd),
      .in_full   (queue_full),
      .out_pop   (head_pop),
      .out_valid (head_valid),
      .out_cmd   (head_cmd)
   );

   mmle_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cmd_valid             (head_valid),
      .cmd                   (head_cmd),
      .cmd_pop               (head_pop),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_first_half_level  (rsp_first_half_level),
      .rsp_second_half_level (rsp_second_half_level),
      .rsp_symbol_kind       (rsp_symbol_kind),
      .rsp_last_of_run       (rsp_last_of_run)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !front_push)
      else $error("command queued while queue full");

endmodule

FILE: hdl/mmle_front.sv
module mmle_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             req_data_bit,
   input  logic             req_end_of_stream,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   input  logic             cmd_full,
   output logic             cmd_push,
   output mmle_pkg::cmd_type cmd
);

   logic [3:0] line_code_ff, line_code_in;
   logic       level_ff, level_in;
   logic       pulse_ff, pulse_in;
   logic [2:0] held_ff, held_in;
   logic       parity_ff, parity_in;

   logic       accept;
   logic       csr_write;
   logic       emit;
   logic [2:0] held_inc;
   logic       pulse_alt;
   logic       d;
   logic       e;

   assign pready    = 1'b1;
   assign full      = cmd_full;
   assign accept    = push && !cmd_full;
   assign csr_write = psel && penable && pwrite &&
                      (paddr[2] == mmle_pkg::CSR_ADDR_LINE_CODE[2]);
   assign prdata    = (paddr[2] == mmle_pkg::CSR_ADDR_LINE_CODE[2]) ?
                      {28'd0, line_code_ff} : 32'd0;
   assign d         = req_data_bit;
   assign e         = req_end_of_stream;
   assign held_inc  = held_ff + 3'd1;
   assign pulse_alt = !pulse_ff;

   always_comb begin
      line_code_in    = line_code_ff;
      level_in        = level_ff;
      pulse_in        = pulse_ff;
      held_in         = held_ff;
      parity_in       = parity_ff;
      emit            = 1'b1;
      cmd.zero_count  = 3'd0;
      cmd.tail        = mmle_pkg::TAIL_SYMBOL;
      cmd.first_half  = mmle_pkg::LEVEL_ZERO;
      cmd.second_half = mmle_pkg::LEVEL_ZERO;
      cmd.kind        = mmle_pkg::KIND_DATA;
      cmd.pulse_pos   = pulse_ff;
      cmd.balance     = 1'b0;
      case (line_code_ff)
         mmle_pkg::CODE_UNIPOLAR: begin
            cmd.first_half  = d ? mmle_pkg::LEVEL_POS : mmle_pkg::LEVEL_ZERO;
            cmd.second_half = d ? mmle_pkg::LEVEL_POS : mmle_pkg::LEVEL_ZERO;
         end
         mmle_pkg::CODE_NRZ_L: begin
            cmd.first_half  = mmle_pkg::pol(d);
            cmd.second_half = mmle_pkg::pol(d);
         end
         mmle_pkg::CODE_NRZ_I: begin
            level_in        = level_ff ^ d;
            cmd.first_half  = mmle_pkg::pol(level_ff ^ d);
            cmd.second_half = mmle_pkg::pol(level_ff ^ d);
         end
         mmle_pkg::CODE_MANCH: begin
            cmd.first_half  = mmle_pkg::pol(!d);
            cmd.second_half = mmle_pkg::pol(d);
         end
         mmle_pkg::CODE_DIFF_MAN: begin
            cmd.first_half  = mmle_pkg::pol(level_ff ^ !d);
            cmd.second_half = mmle_pkg::pol(level_ff ^ d);
            level_in        = level_ff ^ d;
         end
         mmle_pkg::CODE_AMI: begin
            if (d) begin
               pulse_in        = pulse_alt;
               cmd.first_half  = mmle_pkg::pol(pulse_alt);
               cmd.second_half = mmle_pkg::pol(pulse_alt);
            end
         end
         mmle_pkg::CODE_PSEUDO: begin
            if (!d) begin
               pulse_in        = pulse_alt;
               cmd.first_half  = mmle_pkg::pol(pulse_alt);
               cmd.second_half = mmle_pkg::pol(pulse_alt);
            end
         end
         mmle_pkg::CODE_HDB3: begin
            if (d) begin
               cmd.zero_count  = held_ff;
               held_in         = 3'd0;
               pulse_in        = pulse_alt;
               parity_in       = !parity_ff;
               cmd.first_half  = mmle_pkg::pol(pulse_alt);
               cmd.second_half = mmle_pkg::pol(pulse_alt);
            end else if (held_inc >= 3'd4) begin
               held_in     = 3'd0;
               cmd.tail    = mmle_pkg::TAIL_HDB3;
               cmd.balance = !parity_ff;
               pulse_in    = pulse_ff ^ !parity_ff;
               parity_in   = 1'b0;
            end else if (e) begin
               cmd.zero_count = held_inc;
               cmd.tail       = mmle_pkg::TAIL_NONE;
               held_in        = 3'd0;
            end else begin
               held_in = held_inc;
               emit    = 1'b0;
            end
         end
         mmle_pkg::CODE_B8ZS: begin
            if (d) begin
               cmd.zero_count  = held_ff;
               held_in         = 3'd0;
               pulse_in        = pulse_alt;
               cmd.first_half  = mmle_pkg::pol(pulse_alt);
               cmd.second_half = mmle_pkg::pol(pulse_alt);
            end else if (held_ff >= 3'd7) begin
               held_in  = 3'd0;
               cmd.tail = mmle_pkg::TAIL_B8ZS;
            end else if (e) begin
               cmd.zero_count = held_inc;
               cmd.tail       = mmle_pkg::TAIL_NONE;
               held_in        = 3'd0;
            end else begin
               held_in = held_inc;
               emit    = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         line_code_in = line_code_ff;
         level_in     = level_ff;
         pulse_in     = pulse_ff;
         held_in      = held_ff;
         parity_in    = parity_ff;
      end
      if (csr_write) begin
         line_code_in = pwdata[3:0];
         level_in     = (pwdata[3:0] == mmle_pkg::CODE_DIFF_MAN);
         pulse_in     = (pwdata[3:0] == mmle_pkg::CODE_PSEUDO);
         held_in      = 3'd0;
         parity_in    = 1'b0;
      end
   end

   assign cmd_push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_code_ff <= mmle_pkg::CODE_UNIPOLAR;
         level_ff     <= 1'b0;
         pulse_ff     <= 1'b0;
         held_ff      <= 3'd0;
         parity_ff    <= 1'b0;
      end else begin
         line_code_ff <= line_code_in;
         level_ff     <= level_in;
         pulse_ff     <= pulse_in;
         held_ff      <= held_in;
         parity_ff    <= parity_in;
      end
   end

endmodule

FILE: hdl/mmle_cmd_queue.sv
module mmle_cmd_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_push,
   input  mmle_pkg::cmd_type in_cmd,
   output logic              in_full,
   input  logic              out_pop,
   output logic              out_valid,
   output mmle_pkg::cmd_type out_cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   mmle_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign in_full   = (count_ff == FULL_COUNT);
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = in_push && !in_full;
   assign do_pop    = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

FILE: hdl/mmle_back.sv
module mmle_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mmle_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              empty,
   input  logic              pop,
   output logic signed [1:0] rsp_first_half_level,
   output logic signed [1:0] rsp_second_half_level,
   output logic [1:0]        rsp_symbol_kind,
   output logic              rsp_last_of_run
);

   logic [2:0]        idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic signed [1:0] first_ff, second_ff;
   logic [1:0]        kind_ff;
   logic              last_ff;

   logic              advance;
   logic [3:0]        tail_len;
   logic [3:0]        total;
   logic [2:0]        j;
   logic              is_last;
   logic signed [1:0] first_c, second_c;
   mmle_pkg::kind_type kind_c;
   logic              p;

   assign advance = cmd_valid && (!out_valid_ff || pop);
   assign p       = cmd.pulse_pos;
   assign j       = idx_ff - cmd.zero_count;
   assign total   = {1'b0, cmd.zero_count} + tail_len;
   assign is_last = ({1'b0, idx_ff} == (total - 4'd1));
   assign cmd_pop = advance && is_last;
   assign empty   = !out_valid_ff;

   always_comb begin
      case (cmd.tail)
         mmle_pkg::TAIL_SYMBOL: tail_len = 4'd1;
         mmle_pkg::TAIL_HDB3:   tail_len = 4'(mmle_pkg::HDB3_LEN);
         mmle_pkg::TAIL_B8ZS:   tail_len = 4'(mmle_pkg::B8ZS_LEN);
         default:               tail_len = 4'd0;
      endcase
   end

   always_comb begin
      first_c = mmle_pkg::LEVEL_ZERO;
      kind_c  = mmle_pkg::KIND_DATA;
      if (idx_ff >= cmd.zero_count) begin
         case (cmd.tail)
            mmle_pkg::TAIL_SYMBOL: begin
               first_c = cmd.first_half;
               kind_c  = cmd.kind;
            end
            mmle_pkg::TAIL_HDB3: begin
               if (j == 3'd0 && cmd.balance) begin
                  first_c = mmle_pkg::pol(!p);
                  kind_c  = mmle_pkg::KIND_B;
               end else if (j == 3'd3) begin
                  first_c = mmle_pkg::pol(p ^ cmd.balance);
                  kind_c  = mmle_pkg::KIND_V;
               end
            end
            mmle_pkg::TAIL_B8ZS: begin
               case (j)
                  3'd3: begin
                     first_c = mmle_pkg::pol(p);
                     kind_c  = mmle_pkg::KIND_V;
                  end
                  3'd4: begin
                     first_c = mmle_pkg::pol(!p);
                     kind_c  = mmle_pkg::KIND_B;
                  end
                  3'd6: begin
                     first_c = mmle_pkg::pol(!p);
                     kind_c  = mmle_pkg::KIND_V;
                  end
                  3'd7: begin
                     first_c = mmle_pkg::pol(p);
                     kind_c  = mmle_pkg::KIND_B;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      second_c = first_c;
      if (idx_ff >= cmd.zero_count && cmd.tail == mmle_pkg::TAIL_SYMBOL) begin
         second_c = cmd.second_half;
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         idx_in       = is_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         first_ff  <= first_c;
         second_ff <= second_c;
         kind_ff   <= kind_c;
         last_ff   <= is_last;
      end
   end

   assign rsp_first_half_level  = first_ff;
   assign rsp_second_half_level = second_ff;
   assign rsp_symbol_kind       = kind_ff;
   assign rsp_last_of_run       = last_ff;

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> ({1'b0, idx_ff} < total))
      else $error("result index past end of queued transaction");

   a_idx_rewinds: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (idx_ff == 3'd0))
      else $error("result index not cleared after transaction");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

typedef struct {
   logic signed [1:0]  first_half;
   logic signed [1:0]  second_half;
   mmle_pkg::kind_type kind;
   logic               last_of_run;
} line_symbol_type;

class encoder_scoreboard;
   logic [3:0]      line_code;
   bit              level_high;
   bit              last_pulse_pos;
   int unsigned     held_zeros;
   bit              odd_pulses;
   line_symbol_type burst[$];
   line_symbol_type pending_symbols[$];
   int              errors;
   int              bits_seen;
   int              symbols_checked;
   int              violations_seen;
   int              balancing_seen;

   function new();
      errors = 0;
      bits_seen = 0;
      symbols_checked = 0;
      violations_seen = 0;
      balancing_seen = 0;
      set_line_code(mmle_pkg::CODE_UNIPOLAR);
   endfunction

   function void set_line_code(logic [3:0] code);
      line_code = code;
      level_high = (code == mmle_pkg::CODE_DIFF_MAN);
      last_pulse_pos = (code == mmle_pkg::CODE_PSEUDO);
      held_zeros = 0;
      odd_pulses = 0;
   endfunction

   function logic signed [1:0] polarity(bit positive);
      return positive ? mmle_pkg::LEVEL_POS : mmle_pkg::LEVEL_NEG;
   endfunction

   function void emit(logic signed [1:0] a, logic signed [1:0] b, mmle_pkg::kind_type k);
      line_symbol_type s;
      s.first_half = a;
      s.second_half = b;
      s.kind = k;
      s.last_of_run = 1'b0;
      burst.insert(burst.size(), s);
   endfunction

   function void emit_zero();
      emit(mmle_pkg::LEVEL_ZERO, mmle_pkg::LEVEL_ZERO, mmle_pkg::KIND_DATA);
   endfunction

   function void emit_mark(mmle_pkg::kind_type k);
      last_pulse_pos = !last_pulse_pos;
      emit(polarity(last_pulse_pos), polarity(last_pulse_pos), k);
   endfunction

   function void emit_violation();
      emit(polarity(last_pulse_pos), polarity(last_pulse_pos), mmle_pkg::KIND_V);
   endfunction

   function void release_zeros();
      repeat (held_zeros) emit_zero();
      held_zeros = 0;
   endfunction

   function int pending();
      return pending_symbols.size();
   endfunction

   // accepted input transaction
   function void note_transaction(bit d, bit e);
      burst.delete();
      bits_seen++;
      case (line_code)
         mmle_pkg::CODE_UNIPOLAR: begin
            if (d) emit(mmle_pkg::LEVEL_POS, mmle_pkg::LEVEL_POS, mmle_pkg::KIND_DATA);
            else emit_zero();
         end
         mmle_pkg::CODE_NRZ_L: emit(polarity(d), polarity(d), mmle_pkg::KIND_DATA);
         mmle_pkg::CODE_NRZ_I: begin
            level_high = level_high ^ d;
            emit(polarity(level_high), polarity(level_high), mmle_pkg::KIND_DATA);
         end
         mmle_pkg::CODE_MANCH: begin
            if (d) emit(mmle_pkg::LEVEL_NEG, mmle_pkg::LEVEL_POS, mmle_pkg::KIND_DATA);
            else emit(mmle_pkg::LEVEL_POS, mmle_pkg::LEVEL_NEG, mmle_pkg::KIND_DATA);
         end
         mmle_pkg::CODE_DIFF_MAN: begin
            if (d) begin
               emit(polarity(level_high), polarity(!level_high), mmle_pkg::KIND_DATA);
               level_high = !level_high;
            end else begin
               emit(polarity(!level_high), polarity(level_high), mmle_pkg::KIND_DATA);
            end
         end
         mmle_pkg::CODE_AMI: begin
            if (d) emit_mark(mmle_pkg::KIND_DATA);
            else emit_zero();
         end
         mmle_pkg::CODE_PSEUDO: begin
            if (!d) emit_mark(mmle_pkg::KIND_DATA);
            else emit_zero();
         end
         mmle_pkg::CODE_HDB3: begin
            if (d) begin
               release_zeros();
               emit_mark(mmle_pkg::KIND_DATA);
               odd_pulses = !odd_pulses;
            end else begin
               held_zeros = (held_zeros + 1) & 7;
               if (held_zeros >= mmle_pkg::HDB3_LEN) begin
                  held_zeros = 0;
                  if (!odd_pulses) emit_mark(mmle_pkg::KIND_B);
                  else emit_zero();
                  emit_zero();
                  emit_zero();
                  emit_violation();
                  odd_pulses = 0;
               end else if (e) begin
                  release_zeros();
               end
            end
         end
         mmle_pkg::CODE_B8ZS: begin
            if (d) begin
               release_zeros();
               emit_mark(mmle_pkg::KIND_DATA);
            end else if (held_zeros >= mmle_pkg::B8ZS_LEN - 1) begin
               held_zeros = 0;
               emit_zero();
               emit_zero();
               emit_zero();
               emit_violation();
               emit_mark(mmle_pkg::KIND_B);
               emit_zero();
               emit_violation();
               emit_mark(mmle_pkg::KIND_B);
            end else begin
               held_zeros++;
               if (e) release_zeros();
            end
         end
         default: emit_zero();
      endcase
      if (burst.size() > 0) begin
         burst[burst.size() - 1].last_of_run = 1'b1;
         foreach (burst[i]) pending_symbols.insert(pending_symbols.size(), burst[i]);
      end
   endfunction

   // accepted result transaction
   function void check_result(logic signed [1:0] a, logic signed [1:0] b, logic [1:0] k,
                              logic l);
      line_symbol_type s;
      if (pending_symbols.size() == 0) begin
         $error("unexpected symbol: levels %0d/%0d kind %0d last %0d", a, b, k, l);
         errors++;
         return;
      end
      s = pending_symbols.pop_front();
      symbols_checked++;
      if (s.kind == mmle_pkg::KIND_V) violations_seen++;
      if (s.kind == mmle_pkg::KIND_B) balancing_seen++;
      if (a !== s.first_half) begin
         $error("first_half_level: expected %0d, actual %0d", s.first_half, a);
         errors++;
      end
      if (b !== s.second_half) begin
         $error("second_half_level: expected %0d, actual %0d", s.second_half, b);
         errors++;
      end
      if (k !== s.kind) begin
         $error("symbol_kind: expected %0d, actual %0d", s.kind, k);
         errors++;
      end
      if (l !== s.last_of_run) begin
         $error("last_of_run: expected %0d, actual %0d", s.last_of_run, l);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam logic [3:0] CODE_UNUSED_LOW  = 4'd9;
   localparam logic [3:0] CODE_UNUSED_HIGH = 4'd15;
   localparam int DRAIN_CYCLES   = 48;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   logic              clock;
   logic              reset;
   logic              push;
   logic              full;
   logic              req_data_bit;
   logic              req_end_of_stream;
   logic              empty;
   logic              pop;
   logic signed [1:0] rsp_first_half_level;
   logic signed [1:0] rsp_second_half_level;
   logic [1:0]        rsp_symbol_kind;
   logic              rsp_last_of_run;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   encoder_scoreboard sb = new();
   bit pressure_request = 0;
   int idle_cycles = 0;
   int input_stall_cycles = 0;
   int phases = 0;

   multi_mode_line_encoder_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_data_bit          (req_data_bit),
      .req_end_of_stream     (req_end_of_stream),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_first_half_level  (rsp_first_half_level),
      .rsp_second_half_level (rsp_second_half_level),
      .rsp_symbol_kind       (rsp_symbol_kind),
      .rsp_last_of_run       (rsp_last_of_run),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) sb.note_transaction(req_data_bit, req_end_of_stream);
         if (pop && !empty)
            sb.check_result(rsp_first_half_level, rsp_second_half_level, rsp_symbol_kind,
                            rsp_last_of_run);
         if (push && full) input_stall_cycles++;
         if ((push && !full) || (pop && !empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // result side
   initial begin
      int  stall;
      int  got;
      bit  held_off;
      bit  eager;
      pop <= 1'b0;
      got = 0;
      held_off = 0;
      eager = 0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (pressure_request && !held_off) begin
            held_off = 1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = eager ? 0 : pick_gap();
            if (stall > 0) begin
               pop <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         got++;
         if (got % 24 == 0) eager = ($urandom_range(0, 2) == 0);
      end
   end

   task automatic send_bit(input bit d, input bit e, input bit no_gaps);
      int gap;
      req_data_bit <= d;
      req_end_of_stream <= e;
      push <= 1'b1;
      do @(posedge clock); while (full);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write_line_code(input logic [3:0] code);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= mmle_pkg::CSR_ADDR_LINE_CODE;
      pwdata <= {28'd0, code};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_line_code(code);
      // read back
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {28'd0, code}) begin
         $error("line_code readback: expected %0d, actual %0d", code, prdata);
         sb.errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic run_phase(input logic [3:0] code, input bit write_code, input int n_random,
                            input bit busy, input bit pressure, input bit [1:0] directed[$]);
      bit d;
      bit e;
      bit no_gaps;
      wait_idle();
      if (write_code) csr_write_line_code(code);
      phases++;
      no_gaps = busy || ($urandom_range(0, 3) == 0);
      foreach (directed[i]) send_bit(directed[i][1], directed[i][0], no_gaps);
      if (pressure) pressure_request = 1;
      for (int i = 0; i < n_random; i++) begin
         if (code == mmle_pkg::CODE_HDB3 || code == mmle_pkg::CODE_B8ZS) begin
            if ($urandom_range(0, 5) == 0) d = 1'($urandom_range(0, 1));
            else if (code == mmle_pkg::CODE_HDB3) d = ($urandom_range(0, 3) == 0);
            else d = ($urandom_range(0, 6) == 0);
            e = ($urandom_range(0, 7) == 0);
         end else begin
            d = 1'($urandom_range(0, 1));
            e = 1'($urandom_range(0, 1));
         end
         send_bit(d, e, no_gaps);
      end
      push <= 1'b0;
   endtask

   initial begin
      bit [1:0] none[$];
      bit [1:0] hdb3_run[$];
      bit [1:0] b8zs_run[$];
      reset <= 1'b1;
      push <= 1'b0;
      req_data_bit <= 1'b0;
      req_end_of_stream <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      // {data, end}: substitutions at both parities, flushes, end on the completing zero
      hdb3_run = '{2'b00, 2'b00, 2'b00, 2'b00, 2'b10, 2'b00, 2'b00, 2'b00, 2'b00,
                   2'b00, 2'b01, 2'b00, 2'b00, 2'b00, 2'b01, 2'b00, 2'b10};
      b8zs_run = '{2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00, 2'b00};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      run_phase(mmle_pkg::CODE_UNIPOLAR, 1'b0, 12, 1'b0, 1'b0, none);
      run_phase(mmle_pkg::CODE_NRZ_L,    1'b1, 12, 1'b0, 1'b0, none);
      run_phase(mmle_pkg::CODE_NRZ_I,    1'b1, 12, 1'b1, 1'b0, none);
      run_phase(mmle_pkg::CODE_MANCH,    1'b1, 12, 1'b0, 1'b0, none);
      run_phase(mmle_pkg::CODE_DIFF_MAN, 1'b1, 12, 1'b0, 1'b0, none);
      run_phase(mmle_pkg::CODE_AMI,      1'b1, 30, 1'b1, 1'b1, none);
      run_phase(mmle_pkg::CODE_PSEUDO,   1'b1, 12, 1'b0, 1'b0, none);
      run_phase(mmle_pkg::CODE_HDB3,     1'b1, 30, 1'b0, 1'b0, hdb3_run);
      run_phase(mmle_pkg::CODE_B8ZS,     1'b1, 36, 1'b0, 1'b0, b8zs_run);
      run_phase(CODE_UNUSED_LOW,         1'b1, 4,  1'b0, 1'b0, none);
      run_phase(CODE_UNUSED_HIGH,        1'b1, 4,  1'b0, 1'b0, none);
      run_phase(mmle_pkg::CODE_HDB3,     1'b1, 16, 1'b0, 1'b0, none);
      run_phase(mmle_pkg::CODE_B8ZS,     1'b1, 16, 1'b1, 1'b0, none);
      run_phase(mmle_pkg::CODE_UNIPOLAR, 1'b1, 8,  1'b0, 1'b0, none);
      wait_idle();

      $display("Encoded %0d bits over %0d line code phases, including unused codes.",
               sb.bits_seen, phases);
      $display("Checked %0d symbols (%0d violations, %0d balancing pulses); %s %0d cycles.",
               sb.symbols_checked, sb.violations_seen, sb.balancing_seen,
               "input stalled", input_stall_cycles);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
